### src/mma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_pkg
// Shared constants, widths and sequencer states of the multichannel moving
// average unit.
// ----------------------------------------------------------------------------
package mma_pkg;

  // Sizing
  localparam int CHANNELS    = 20;
  localparam int MAX_WINDOW  = 20;
  localparam int SAMPLE_BITS = 16;

  // Port field widths (fixed)
  localparam int CHAN_FIELD_W = 8;
  localparam int SMP_FIELD_W  = 16;
  localparam int WIN_FIELD_W  = 8;
  localparam int VAL_FIELD_W  = 16;

  // Derived internal widths
  localparam int SMP_W   = (SAMPLE_BITS < SMP_FIELD_W) ? SAMPLE_BITS : SMP_FIELD_W;
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SUM_W   = SMP_W + WIN_W;
  localparam int RING_D  = CHANNELS * MAX_WINDOW;
  localparam int RA_W    = (RING_D > 1) ? $clog2(RING_D) : 1;
  localparam int CNT_W   = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_READ,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

### src/mma_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_if
// Valid/ready channels of the moving average unit: sample in, result out.
// ----------------------------------------------------------------------------
interface mma_in_if;
  logic                                valid;
  logic                                ready;
  logic [mma_pkg::CHAN_FIELD_W-1:0]    channel;
  logic [mma_pkg::SMP_FIELD_W-1:0]     sample;
  logic [mma_pkg::WIN_FIELD_W-1:0]     window;

  modport source (output valid, output channel, output sample, output window,
                  input ready);
  modport sink   (input valid, input channel, input sample, input window,
                  output ready);
endinterface

interface mma_out_if;
  logic                                valid;
  logic                                ready;
  logic [mma_pkg::VAL_FIELD_W-1:0]     value;
  logic                                filtered;

  modport source (output valid, output value, output filtered, input ready);
  modport sink   (input valid, input value, input filtered, output ready);
endinterface

### src/multichannel_moving_average_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_moving_average_unit
// Per-channel boxcar moving average with a shared bit-serial divider.
// ----------------------------------------------------------------------------
// Each transfer on in_chan carries a channel, a sample and a window. Channels
// below CHANNELS keep a ring of up to MAX_WINDOW samples in a single-port
// RAM plus a write position, fill count and running sum; the result is the
// sum divided by the fill count while filling and by the window once full,
// truncated. A zero window or out-of-range channel passes the sample
// straight through with filtered low, going from the transfer through the
// hand-over state and back to idle. An averaged item goes from the transfer
// through a state of lookup and ring read, one of ring update, the
// restoring divider (one quotient bit per cycle over the SUM_W-bit
// quotient), the hand-over state and a return to idle. The result sits in
// an output register, so the next sample is taken while it waits; the
// hand-over cycle stretches for as long as an earlier result is still
// waiting there. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module multichannel_moving_average_unit (
  input  logic              clk,
  input  logic              rst_n,
  mma_in_if.sink            in_chan,
  mma_out_if.source         out_chan
);

  // Sequencer and item registers
  mma_pkg::state_t                 state_r, state_nxt;
  logic [mma_pkg::CH_W-1:0]        ch_r;
  logic [mma_pkg::SMP_W-1:0]       smp_r;
  logic [mma_pkg::WIN_W-1:0]       win_r;
  logic                            byp_r;

  // Per-channel state
  logic [mma_pkg::WIN_W-1:0]       chan_win_r [mma_pkg::CHANNELS];
  logic [mma_pkg::WIN_W-1:0]       wpos_r     [mma_pkg::CHANNELS];
  logic [mma_pkg::WIN_W-1:0]       fill_r     [mma_pkg::CHANNELS];
  logic [mma_pkg::SUM_W-1:0]       sum_r      [mma_pkg::CHANNELS];

  // Sample ring
  logic [mma_pkg::SMP_W-1:0]       ring_mem   [mma_pkg::RING_D];
  logic [mma_pkg::SMP_W-1:0]       ring_rd_r;

  // Working registers of the current item
  logic [mma_pkg::WIN_W-1:0]       pos_r;
  logic [mma_pkg::WIN_W-1:0]       cnt_fill_r;
  logic [mma_pkg::SUM_W-1:0]       acc_r;
  logic                            full_r;
  logic [mma_pkg::RA_W-1:0]        slot_r;

  // Divider
  logic [mma_pkg::SUM_W-1:0]       quot_r;
  logic [mma_pkg::WIN_W-1:0]       rem_r;
  logic [mma_pkg::WIN_W-1:0]       div_r;
  logic [mma_pkg::CNT_W-1:0]       cnt_r;

  // Output register
  logic                            out_valid_r;
  logic [mma_pkg::VAL_FIELD_W-1:0] out_value_r;
  logic                            out_filt_r;

  logic                            in_xfer;
  logic                            out_xfer;
  logic                            in_byp;
  logic [mma_pkg::WIN_W-1:0]       in_win;
  logic                            changed;
  logic [mma_pkg::WIN_W-1:0]       pos0, pos_sel, fill0;
  logic [mma_pkg::SUM_W-1:0]       sum0, sum_new;
  logic [mma_pkg::WIN_W-1:0]       pos_inc, pos_wrap, fill_inc;
  logic [mma_pkg::RA_W-1:0]        slot;
  logic [mma_pkg::WIN_W:0]         rem_sh, rem_sub;
  logic                            ge;
  logic                            done_ok;

  assign in_chan.ready     = (state_r == mma_pkg::ST_IDLE);
  assign in_xfer           = in_chan.valid && in_chan.ready;
  assign out_xfer          = out_valid_r && out_chan.ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.value    = out_value_r;
  assign out_chan.filtered = out_filt_r;

  // Input decode: bypass test and window clamp
  assign in_byp = (in_chan.window == '0) ||
                  (in_chan.channel >= mma_pkg::CHAN_FIELD_W'(mma_pkg::CHANNELS));
  assign in_win = (in_chan.window > mma_pkg::WIN_FIELD_W'(mma_pkg::MAX_WINDOW)) ?
                  mma_pkg::WIN_W'(mma_pkg::MAX_WINDOW) :
                  mma_pkg::WIN_W'(in_chan.window);

  // Lookup stage: a new window restarts the channel
  assign changed = (chan_win_r[ch_r] != win_r);
  assign pos0    = changed ? '0 : wpos_r[ch_r];
  assign fill0   = changed ? '0 : fill_r[ch_r];
  assign sum0    = changed ? '0 : sum_r[ch_r];
  assign pos_sel = (pos0 >= win_r) ? '0 : pos0;
  assign slot    = mma_pkg::RA_W'(ch_r) * mma_pkg::RA_W'(mma_pkg::MAX_WINDOW)
                 + mma_pkg::RA_W'(pos_sel);

  // Update stage: drop the oldest entry once full, add the new one
  assign sum_new  = acc_r - (full_r ? mma_pkg::SUM_W'(ring_rd_r) : '0)
                  + mma_pkg::SUM_W'(smp_r);
  assign pos_inc  = pos_r + 1'b1;
  assign pos_wrap = (pos_inc >= win_r) ? '0 : pos_inc;
  assign fill_inc = cnt_fill_r + 1'b1;

  // Restoring divider step
  assign rem_sh  = {rem_r, quot_r[mma_pkg::SUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, div_r});
  assign rem_sub = ge ? (rem_sh - {1'b0, div_r}) : rem_sh;

  assign done_ok = !out_valid_r || out_chan.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mma_pkg::ST_IDLE: begin
        if (in_xfer) state_nxt = in_byp ? mma_pkg::ST_DONE : mma_pkg::ST_LOOK;
      end
      mma_pkg::ST_LOOK: state_nxt = mma_pkg::ST_READ;
      mma_pkg::ST_READ: state_nxt = mma_pkg::ST_DIV;
      mma_pkg::ST_DIV: begin
        if (cnt_r == mma_pkg::CNT_W'(mma_pkg::SUM_W - 1)) state_nxt = mma_pkg::ST_DONE;
      end
      mma_pkg::ST_DONE: begin
        if (done_ok) state_nxt = mma_pkg::ST_IDLE;
      end
      default: state_nxt = mma_pkg::ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mma_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ch_r  <= mma_pkg::CH_W'(in_chan.channel);
      smp_r <= mma_pkg::SMP_W'(in_chan.sample);
      win_r <= in_win;
      byp_r <= in_byp;
    end
  end

  // Per-channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mma_pkg::CHANNELS; i++) begin
        chan_win_r[i] <= '0;
        wpos_r[i]     <= '0;
        fill_r[i]     <= '0;
        sum_r[i]      <= '0;
      end
    end else if (state_r == mma_pkg::ST_LOOK) begin
      chan_win_r[ch_r] <= win_r;
    end else if (state_r == mma_pkg::ST_READ) begin
      wpos_r[ch_r] <= pos_wrap;
      fill_r[ch_r] <= full_r ? cnt_fill_r : fill_inc;
      sum_r[ch_r]  <= sum_new;
    end
  end

  // Sample ring: one read in lookup, one write in update
  always_ff @(posedge clk) begin
    if (state_r == mma_pkg::ST_LOOK) ring_rd_r <= ring_mem[slot];
    if (state_r == mma_pkg::ST_READ) ring_mem[slot_r] <= smp_r;
  end

  // Working registers and divider
  always_ff @(posedge clk) begin
    case (state_r)
      mma_pkg::ST_LOOK: begin
        pos_r      <= pos_sel;
        cnt_fill_r <= fill0;
        acc_r      <= sum0;
        full_r     <= (fill0 >= win_r);
        slot_r     <= slot;
      end
      mma_pkg::ST_READ: begin
        quot_r <= sum_new;
        rem_r  <= '0;
        div_r  <= full_r ? win_r : fill_inc;
        cnt_r  <= '0;
      end
      mma_pkg::ST_DIV: begin
        quot_r <= {quot_r[mma_pkg::SUM_W-2:0], ge};
        rem_r  <= rem_sub[mma_pkg::WIN_W-1:0];
        cnt_r  <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == mma_pkg::ST_DONE && done_ok) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mma_pkg::ST_DONE && done_ok) begin
      out_value_r <= byp_r ? mma_pkg::VAL_FIELD_W'(smp_r)
                           : mma_pkg::VAL_FIELD_W'(quot_r);
      out_filt_r  <= !byp_r;
    end
  end

  // Checks
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mma_pkg::ST_DIV |-> div_r != '0)
    else $error("divider running with zero divisor");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mma_pkg::ST_READ |=>
      fill_r[ch_r] <= chan_win_r[ch_r] && fill_r[ch_r] != '0)
    else $error("fill count out of range after update");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_chan.ready)
    else $error("ready held high after a transfer");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mma_pkg::ST_DIV |-> cnt_r < mma_pkg::CNT_W'(mma_pkg::SUM_W))
    else $error("divider step count overrun");

  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mma_pkg::ST_DONE && done_ok |=> out_valid_r && in_chan.ready)
    else $error("result not loaded on hand-over");

endmodule
